FILE: hdl/lzrw3_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lzrw3_pkg
// Shared types, constants and the start string for the LZRW3 decompressor.
// ---------------------------------------------------------------------------
package lzrw3_pkg;

  localparam int PAGE_BYTES = 4096;
  localparam int HIST_AW    = 12;
  localparam int HASH_AW    = 12;
  localparam int WP_W       = 13;
  localparam int EPOCH_W    = 8;
  localparam int POS_W      = 13;

  localparam logic [POS_W-1:0] START_MARK = 13'h1000;
  localparam logic [15:0]      HASH_MUL   = 16'd40543;

  localparam logic [1:0] CMD_NOP  = 2'd0;
  localparam logic [1:0] CMD_LIT  = 2'd1;
  localparam logic [1:0] CMD_COPY = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic       last;
    logic [7:0] data;
    logic [3:0] idx_hi;
    logic [3:0] lenm;
  } cmd_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ovr;
  } out_item_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] tag;
    logic [POS_W-1:0]   pos;
  } hash_ent_t;

  function automatic logic [7:0] start_byte(input logic [4:0] off);
    logic [7:0] b;
    case (off)
      5'd0, 5'd10:  b = 8'h31;
      5'd1, 5'd11:  b = 8'h32;
      5'd2, 5'd12:  b = 8'h33;
      5'd3, 5'd13:  b = 8'h34;
      5'd4, 5'd14:  b = 8'h35;
      5'd5, 5'd15:  b = 8'h36;
      5'd6, 5'd16:  b = 8'h37;
      5'd7, 5'd17:  b = 8'h38;
      5'd8:         b = 8'h39;
      5'd9:         b = 8'h30;
      default:      b = 8'h00;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/lzrw3_front.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lzrw3_front
// Parses control words and items into literal/copy commands; two-entry
// command queue toward the back end.
// ---------------------------------------------------------------------------
module lzrw3_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_last,
  output logic                  cmd_valid,
  output lzrw3_pkg::cmd_t       cmd,
  input  wire logic             cmd_pop
);
  import lzrw3_pkg::*;

  logic [1:0]  phase_r, phase_nxt;
  logic [16:0] ctrl_r, ctrl_nxt;
  logic [7:0]  cfb_r, cfb_nxt;
  cmd_t        q_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        acc, q_push, q_pop;
  cmd_t        new_cmd;
  logic [16:0] ctrl_sh;

  assign full      = (cnt_r == 2'd2);
  assign acc       = push && !full;
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rp_r];
  assign q_pop     = cmd_pop && cmd_valid;
  assign ctrl_sh   = ctrl_r >> 1;

  always_comb begin
    phase_nxt      = phase_r;
    ctrl_nxt       = ctrl_r;
    cfb_nxt        = cfb_r;
    new_cmd.kind   = CMD_NOP;
    new_cmd.last   = in_last;
    new_cmd.data   = in_byte;
    new_cmd.idx_hi = cfb_r[7:4];
    new_cmd.lenm   = cfb_r[3:0];
    case (phase_r)
      2'd0: begin
        ctrl_nxt  = {1'b1, 8'h00, in_byte};
        phase_nxt = 2'd1;
      end
      2'd1: begin
        ctrl_nxt  = {ctrl_r[16], in_byte, ctrl_r[7:0]};
        phase_nxt = 2'd2;
      end
      2'd2: begin
        if (ctrl_r[0]) begin
          cfb_nxt   = in_byte;
          phase_nxt = 2'd3;
        end else begin
          new_cmd.kind = CMD_LIT;
          ctrl_nxt     = ctrl_sh;
          phase_nxt    = (ctrl_sh == 17'd1) ? 2'd0 : 2'd2;
        end
      end
      default: begin
        new_cmd.kind = CMD_COPY;
        ctrl_nxt     = ctrl_sh;
        phase_nxt    = (ctrl_sh == 17'd1) ? 2'd0 : 2'd2;
      end
    endcase
    if (in_last) begin
      phase_nxt = 2'd0;
      ctrl_nxt  = 17'd1;
      cfb_nxt   = 8'h00;
    end
  end

  assign q_push = acc && (new_cmd.kind != CMD_NOP || in_last);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
      ctrl_r  <= 17'd1;
      cfb_r   <= 8'h00;
      wp_r    <= 1'b0;
      rp_r    <= 1'b0;
      cnt_r   <= 2'd0;
    end else begin
      if (acc) begin
        phase_r <= phase_nxt;
        ctrl_r  <= ctrl_nxt;
        cfb_r   <= cfb_nxt;
      end
      if (q_push) wp_r <= ~wp_r;
      if (q_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, q_push} - {1'b0, q_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (q_push) q_r[wp_r] <= new_cmd;
  end

endmodule
`default_nettype wire

FILE: hdl/lzrw3_back.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lzrw3_back
// Executes commands: history and hash table memories, copy engine,
// hash update sequencer, page-end epoch and clearing pass.
// ---------------------------------------------------------------------------
module lzrw3_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cmd_valid,
  input  wire lzrw3_pkg::cmd_t   cmd,
  output logic                   cmd_pop,
  input  wire logic              oq_full,
  output logic                   emit,
  output lzrw3_pkg::out_item_t   emit_item
);
  import lzrw3_pkg::*;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_HRD  = 3'd2;
  localparam logic [2:0] S_COPY = 3'd3;
  localparam logic [2:0] S_HMUL = 3'd4;
  localparam logic [2:0] S_HWR  = 3'd5;
  localparam logic [2:0] S_IDXW = 3'd6;
  localparam logic [2:0] S_PEND = 3'd7;

  logic [7:0]      hist [1<<HIST_AW];
  hash_ent_t       ht   [1<<HASH_AW];
  logic [7:0]      hist_q_r;
  hash_ent_t       ht_q_r;

  logic [2:0]         st_r, st_nxt;
  logic [HASH_AW-1:0] clr_r, clr_nxt;
  logic [EPOCH_W-1:0] epoch_r, epoch_nxt;
  logic [WP_W-1:0]    wp_r, wp_nxt;
  logic [1:0]         pend_r, pend_nxt;
  logic [7:0]         b1_r, b1_nxt, b2_r, b2_nxt;
  logic [7:0]         p1_r, p1_nxt, p2_r, p2_nxt, c0_r, c0_nxt, c1_r, c1_nxt;
  logic [HASH_AW-1:0] idx_r, idx_nxt;
  logic [3:0]         lenm_r, lenm_nxt;
  logic               last_r, last_nxt;
  logic [POS_W-1:0]   src_r, src_nxt;
  logic [4:0]         k_r, k_nxt;
  logic               ok_r, ok_nxt;
  logic [WP_W-1:0]    start_r, start_nxt;
  logic [15:0]        hv_r, hv_nxt, prod_r, prod_nxt;
  logic [POS_W-1:0]   hpos_r, hpos_nxt;
  logic               ph2_r, ph2_nxt;
  logic               hlit_r, hlit_nxt;
  logic               fwd_r, fwd_nxt;
  logic [7:0]         fwd_d_r, fwd_d_nxt;

  logic               hist_re, ht_re, ht_we;
  logic [HIST_AW-1:0] hist_ra, nxt_ra;
  logic [HASH_AW-1:0] ht_ra, ht_wa;
  hash_ent_t          ht_wd;
  logic               room, ok_emit, hist_we;
  logic [7:0]         emit_byte, copy_byte;
  logic [2:0]         done_st;
  logic [POS_W-1:0]   hsrc;

  assign room    = (wp_r < WP_W'(PAGE_BYTES));
  assign done_st = last_r ? S_PEND : S_IDLE;
  assign hsrc    = (ht_q_r.tag == epoch_r) ? ht_q_r.pos : START_MARK;
  assign nxt_ra  = src_r[HIST_AW-1:0] + HIST_AW'(k_r) + HIST_AW'(1);
  assign copy_byte = !ok_r ? 8'h00 :
                     src_r[POS_W-1] ? start_byte(k_r) :
                     (fwd_r ? fwd_d_r : hist_q_r);

  always_comb begin
    st_nxt = st_r;     clr_nxt = clr_r;   epoch_nxt = epoch_r;
    wp_nxt = wp_r;     pend_nxt = pend_r; b1_nxt = b1_r;  b2_nxt = b2_r;
    p1_nxt = p1_r;     p2_nxt = p2_r;     c0_nxt = c0_r;  c1_nxt = c1_r;
    idx_nxt = idx_r;   lenm_nxt = lenm_r; last_nxt = last_r;
    src_nxt = src_r;   k_nxt = k_r;       ok_nxt = ok_r;  start_nxt = start_r;
    hv_nxt = hv_r;     prod_nxt = prod_r; hpos_nxt = hpos_r; ph2_nxt = ph2_r;
    hlit_nxt = hlit_r;
    fwd_nxt = fwd_r;   fwd_d_nxt = fwd_d_r;
    cmd_pop = 1'b0;    emit = 1'b0;       emit_byte = 8'h00;
    emit_item.last = 1'b1;
    hist_re = 1'b0;    hist_ra = src_r[HIST_AW-1:0];
    ht_re = 1'b0;      ht_ra = {cmd.idx_hi, cmd.data};
    ht_we = 1'b0;      ht_wa = clr_r;
    ht_wd.tag = epoch_r; ht_wd.pos = START_MARK;
    case (st_r)
      S_CLR: begin
        ht_we   = 1'b1;
        clr_nxt = clr_r + HASH_AW'(1);
        if (clr_r == '1) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (cmd_valid) begin
          last_nxt = cmd.last;
          case (cmd.kind)
            CMD_LIT: begin
              if (!oq_full) begin
                cmd_pop   = 1'b1;
                emit      = 1'b1;
                emit_byte = cmd.data;
                st_nxt    = cmd.last ? S_PEND : S_IDLE;
                if (room && pend_r == 2'd2) begin
                  hv_nxt   = {b2_r, 8'h00} ^ {4'h0, b1_r, 4'h0} ^ {8'h00, cmd.data};
                  hpos_nxt = wp_r - WP_W'(2);
                  ph2_nxt  = 1'b0;
                  hlit_nxt = 1'b1;
                  st_nxt   = S_HMUL;
                end else if (room) begin
                  pend_nxt = pend_r + 2'd1;
                end
              end
            end
            CMD_COPY: begin
              cmd_pop   = 1'b1;
              ht_re     = 1'b1;
              idx_nxt   = {cmd.idx_hi, cmd.data};
              lenm_nxt  = cmd.lenm;
              p1_nxt    = b1_r;
              p2_nxt    = b2_r;
              start_nxt = wp_r;
              k_nxt     = 5'd0;
              ok_nxt    = 1'b1;
              hlit_nxt  = 1'b0;
              st_nxt    = S_HRD;
            end
            default: begin
              cmd_pop = 1'b1;
              st_nxt  = S_PEND;
            end
          endcase
        end
      end
      S_HRD: begin
        src_nxt = hsrc;
        hist_re = 1'b1;
        hist_ra = hsrc[HIST_AW-1:0];
        fwd_nxt = 1'b0;
        st_nxt  = S_COPY;
      end
      S_COPY: begin
        if (!oq_full) begin
          emit           = 1'b1;
          emit_byte      = copy_byte;
          emit_item.last = (k_r == 5'(lenm_r) + 5'd2);
          ok_nxt         = ok_r && room;
          if (k_r == 5'd0) c0_nxt = copy_byte;
          if (k_r == 5'd1) c1_nxt = copy_byte;
          k_nxt     = k_r + 5'd1;
          hist_re   = 1'b1;
          hist_ra   = nxt_ra;
          fwd_nxt   = room && (nxt_ra == wp_r[HIST_AW-1:0]);
          fwd_d_nxt = copy_byte;
          if (emit_item.last) begin
            st_nxt = done_st;
            if (ok_r && room) begin
              case (pend_r)
                2'd2: begin
                  hv_nxt   = {p2_r, 8'h00} ^ {4'h0, p1_r, 4'h0} ^ {8'h00, c0_nxt};
                  hpos_nxt = start_r - WP_W'(2);
                  ph2_nxt  = 1'b1;
                  st_nxt   = S_HMUL;
                end
                2'd1: begin
                  hv_nxt   = {p1_r, 8'h00} ^ {4'h0, c0_r, 4'h0} ^ {8'h00, c1_nxt};
                  hpos_nxt = start_r - WP_W'(1);
                  ph2_nxt  = 1'b0;
                  st_nxt   = S_HMUL;
                end
                default: st_nxt = S_IDXW;
              endcase
            end
          end
        end
      end
      S_HMUL: begin
        prod_nxt = hv_r * HASH_MUL;
        st_nxt   = S_HWR;
      end
      S_HWR: begin
        ht_we     = 1'b1;
        ht_wa     = prod_r[15:4];
        ht_wd.pos = hpos_r;
        if (ph2_r) begin
          hv_nxt   = {p1_r, 8'h00} ^ {4'h0, c0_r, 4'h0} ^ {8'h00, c1_r};
          hpos_nxt = start_r - WP_W'(1);
          ph2_nxt  = 1'b0;
          st_nxt   = S_HMUL;
        end else if (hlit_r) begin
          st_nxt = done_st;
        end else begin
          st_nxt = S_IDXW;
        end
      end
      S_IDXW: begin
        ht_we     = 1'b1;
        ht_wa     = idx_r;
        ht_wd.pos = start_r;
        pend_nxt  = 2'd0;
        st_nxt    = done_st;
      end
      default: begin
        wp_nxt    = '0;
        pend_nxt  = 2'd0;
        epoch_nxt = epoch_r + EPOCH_W'(1);
        clr_nxt   = '0;
        st_nxt    = (epoch_nxt == '0) ? S_CLR : S_IDLE;
      end
    endcase
    ok_emit = emit && room;
    hist_we = ok_emit;
    if (emit) begin
      if (room) begin
        wp_nxt = wp_r + WP_W'(1);
        b2_nxt = b1_r;
        b1_nxt = emit_byte;
      end else begin
        wp_nxt = WP_W'(PAGE_BYTES);
      end
    end
    emit_item.data = room ? emit_byte : 8'h00;
    emit_item.ovr  = !room;
    if (st_r == S_COPY && emit && emit_item.last) k_nxt = 5'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_CLR;
      clr_r   <= '0;
      epoch_r <= '0;
      wp_r    <= '0;
      pend_r  <= 2'd0;
      k_r     <= 5'd0;
    end else begin
      st_r    <= st_nxt;
      clr_r   <= clr_nxt;
      epoch_r <= epoch_nxt;
      wp_r    <= wp_nxt;
      pend_r  <= pend_nxt;
      k_r     <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    b1_r <= b1_nxt;   b2_r <= b2_nxt;   p1_r <= p1_nxt;   p2_r <= p2_nxt;
    c0_r <= c0_nxt;   c1_r <= c1_nxt;   idx_r <= idx_nxt; lenm_r <= lenm_nxt;
    last_r <= last_nxt; src_r <= src_nxt; ok_r <= ok_nxt; start_r <= start_nxt;
    hv_r <= hv_nxt;   prod_r <= prod_nxt; hpos_r <= hpos_nxt; ph2_r <= ph2_nxt;
    hlit_r <= hlit_nxt;
    fwd_r <= fwd_nxt; fwd_d_r <= fwd_d_nxt;
  end

  always_ff @(posedge clk) begin
    if (hist_we) hist[wp_r[HIST_AW-1:0]] <= emit_byte;
    if (hist_re) hist_q_r <= hist[hist_ra];
  end

  always_ff @(posedge clk) begin
    if (ht_we) ht[ht_wa] <= ht_wd;
    if (ht_re) ht_q_r <= ht[ht_ra];
  end

  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wp_r <= WP_W'(PAGE_BYTES)) else $error("write position past page");
  a_pend_range: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3) else $error("pending literal count out of range");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_pop |-> (st_r == S_IDLE && cmd_valid)) else $error("pop outside idle");
  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> !oq_full) else $error("emit into full queue");

endmodule
`default_nettype wire

FILE: hdl/lzrw3_out_queue.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lzrw3_out_queue
// Four-entry result queue between the back end and the output port.
// ---------------------------------------------------------------------------
module lzrw3_out_queue (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr,
  input  wire lzrw3_pkg::out_item_t  wr_item,
  output logic                       q_full,
  output logic                       empty,
  input  wire logic                  pop,
  output lzrw3_pkg::out_item_t       head
);
  import lzrw3_pkg::*;

  out_item_t  q_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;
  logic       rd;

  assign q_full = (cnt_r == 3'd4);
  assign empty  = (cnt_r == 3'd0);
  assign head   = q_r[rp_r];
  assign rd     = pop && !empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 2'd0;
      rp_r  <= 2'd0;
      cnt_r <= 3'd0;
    end else begin
      if (wr) wp_r <= wp_r + 2'd1;
      if (rd) rp_r <= rp_r + 2'd1;
      cnt_r <= cnt_r + {2'b0, wr} - {2'b0, rd};
    end
  end

  always_ff @(posedge clk) begin
    if (wr) q_r[wp_r] <= wr_item;
  end

endmodule
`default_nettype wire

FILE: hdl/lzrw3_page_decompressor.sv
`default_nettype none
// ---------------------------------------------------------------------------
// lzrw3_page_decompressor
// LZRW3 page decompressor, one compressed byte in, one page byte out.
// ---------------------------------------------------------------------------
// Control bytes and the first byte of a copy item are absorbed by the
// front parser; literal and copy commands are buffered in a two-entry
// command queue. A literal may trigger a hash update (multiply, then write).
// A copy of L bytes does a hash table read, a history read, then one byte
// per cycle while the result queue is not full, followed by any hash updates
// and the index update. Page end advances the epoch; after reset and after
// every 256th page the hash table is swept, during which no command is
// executed. Results wait in a four-entry queue.
// ---------------------------------------------------------------------------
module lzrw3_page_decompressor (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last,
  output logic             empty,
  input  wire logic        pop,
  output logic [7:0]       out_byte,
  output logic             out_last,
  output logic             overrun
);
  import lzrw3_pkg::*;

  logic      cmd_valid, cmd_pop, oq_full, emit;
  cmd_t      cmd;
  out_item_t emit_item, head;

  lzrw3_front u_front (
    .clk, .rst_n, .push, .full, .in_byte, .in_last,
    .cmd_valid, .cmd, .cmd_pop
  );

  lzrw3_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd, .cmd_pop, .oq_full, .emit, .emit_item
  );

  lzrw3_out_queue u_oq (
    .clk, .rst_n, .wr(emit), .wr_item(emit_item), .q_full(oq_full),
    .empty, .pop, .head
  );

  assign out_byte = head.data;
  assign out_last = head.last;
  assign overrun  = head.ovr;

endmodule
`default_nettype wire
